[rtl/core/p80dc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package p80dc_pkg;

	localparam int BLK_W = 64;
	localparam int KEY_W = 80;
	localparam int RC_W  = 5;
	localparam int CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_DUP_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_DUP_HIGH = 2'd3;

	localparam logic [3:0] SBOX [16] = '{
		4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
		4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
	};

	typedef struct packed {
		logic [BLK_W-1:0] st;
		logic [KEY_W-1:0] key;
	} lane_t;

	function automatic logic [BLK_W-1:0] round_key(input logic [KEY_W-1:0] key);
		return key[KEY_W-1 -: BLK_W];
	endfunction

	function automatic logic [BLK_W-1:0] sbox_layer(input logic [BLK_W-1:0] s);
		logic [BLK_W-1:0] r;
		r = '0;
		for (int n = 0; n < BLK_W / 4; n++) begin
			r[4*n +: 4] = SBOX[s[4*n +: 4]];
		end
		return r;
	endfunction

	// bit b moves to 16*b mod 63, which is a 6-bit rotate left by 4; bit 63 stays
	function automatic logic [BLK_W-1:0] perm_layer(input logic [BLK_W-1:0] s);
		logic [BLK_W-1:0] r;
		logic [5:0]       b;
		r = '0;
		for (int i = 0; i < BLK_W; i++) begin
			b = 6'(i);
			r[{b[1:0], b[5:2]}] = s[i];
		end
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] key_next(input logic [KEY_W-1:0] key,
	                                              input logic [RC_W-1:0]  rc);
		logic [KEY_W-1:0] k;
		k = {key[18:0], key[KEY_W-1:19]};
		k[KEY_W-1 -: 4] = SBOX[k[KEY_W-1 -: 4]];
		k[19:15] = k[19:15] ^ rc;
		return k;
	endfunction

	function automatic logic lanes_differ(input lane_t a, input lane_t b);
		return (a.st != b.st) || (a.key != b.key);
	endfunction

endpackage

`default_nettype wire

[rtl/core/present80_block_encrypt_dual_check.sv]
`timescale 1ns / 1ps
`default_nettype none

// PRESENT-80 encryption of one 64-bit block with a duplicated lane for fault
// detection. A block is taken with start whenever busy is low, which is every
// cycle: the pipeline has an input register, one register stage per round
// (ROUNDS stages) and an output register; each result is marked by a one-cycle
// done, and a new block may follow in every cycle. The receiver cannot stall
// the outputs. ciphertext always comes from the primary lane; fault is set
// when the plaintexts, the keys, or the lane states and keys differ at any
// round boundary, or when the two final results differ. Keys must be written
// through the cfg port only while no block is in flight; the block itself
// does not enforce this.

module present80_block_encrypt_dual_check
	import p80dc_pkg::*;
#(
	parameter int ROUNDS = 31
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [BLK_W-1:0]     plaintext,
	input  wire logic [BLK_W-1:0]     plaintext_dup,
	output logic                      done,
	output logic [BLK_W-1:0]          ciphertext,
	output logic                      fault,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BLK_W-1:0]     cfg_data
);

	logic [BLK_W-1:0] key_low_q;
	logic [15:0]      key_high_q;
	logic [BLK_W-1:0] key_dup_low_q;
	logic [15:0]      key_dup_high_q;

	lane_t lane_a [ROUNDS+1];
	lane_t lane_b [ROUNDS+1];
	logic  vld    [ROUNDS+1];
	logic  flt    [ROUNDS+1];

	lane_t lane_a_s0;
	lane_t lane_b_s0;
	logic  vld_s0;
	logic  flt_s0;
	lane_t in_a;
	lane_t in_b;

	logic [BLK_W-1:0] fin_a;
	logic [BLK_W-1:0] fin_b;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q      <= '0;
			key_high_q     <= '0;
			key_dup_low_q  <= '0;
			key_dup_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY_LOW:      key_low_q      <= cfg_data;
				REG_KEY_HIGH:     key_high_q     <= cfg_data[15:0];
				REG_KEY_DUP_LOW:  key_dup_low_q  <= cfg_data;
				REG_KEY_DUP_HIGH: key_dup_high_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		in_a.st  = plaintext;
		in_a.key = {key_high_q, key_low_q};
		in_b.st  = plaintext_dup;
		in_b.key = {key_dup_high_q, key_dup_low_q};
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		lane_a_s0 <= in_a;
		lane_b_s0 <= in_b;
		flt_s0    <= lanes_differ(in_a, in_b);
	end

	assign lane_a[0] = lane_a_s0;
	assign lane_b[0] = lane_b_s0;
	assign vld[0]    = vld_s0;
	assign flt[0]    = flt_s0;

	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		p80dc_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.rc        (RC_W'(r + 1)),
			.vld_in    (vld[r]),
			.flt_in    (flt[r]),
			.lane_a_in (lane_a[r]),
			.lane_b_in (lane_b[r]),
			.vld_s1    (vld[r+1]),
			.flt_s1    (flt[r+1]),
			.lane_a_s1 (lane_a[r+1]),
			.lane_b_s1 (lane_b[r+1])
		);
	end

	// final whitening key
	assign fin_a = lane_a[ROUNDS].st ^ round_key(lane_a[ROUNDS].key);
	assign fin_b = lane_b[ROUNDS].st ^ round_key(lane_b[ROUNDS].key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		ciphertext <= fin_a;
		fault      <= flt[ROUNDS] | (fin_a != fin_b);
	end

endmodule

`default_nettype wire

[rtl/core/p80dc_round.sv]
`timescale 1ns / 1ps
`default_nettype none

module p80dc_round
	import p80dc_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [RC_W-1:0] rc,
	input  wire logic            vld_in,
	input  wire logic            flt_in,
	input  wire lane_t           lane_a_in,
	input  wire lane_t           lane_b_in,
	output logic                 vld_s1,
	output logic                 flt_s1,
	output lane_t                lane_a_s1,
	output lane_t                lane_b_s1
);

	lane_t nxt_a;
	lane_t nxt_b;

	always_comb begin
		nxt_a.st  = perm_layer(sbox_layer(lane_a_in.st ^ round_key(lane_a_in.key)));
		nxt_a.key = key_next(lane_a_in.key, rc);
		nxt_b.st  = perm_layer(sbox_layer(lane_b_in.st ^ round_key(lane_b_in.key)));
		nxt_b.key = key_next(lane_b_in.key, rc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		lane_a_s1 <= nxt_a;
		lane_b_s1 <= nxt_b;
		flt_s1    <= flt_in | lanes_differ(nxt_a, nxt_b);
	end

endmodule

`default_nettype wire

[bench/present80_block_encrypt_dual_check_tb.sv]
`timescale 1ns / 1ps

module present80_block_encrypt_dual_check_tb
	import p80dc_pkg::*;
;

	localparam int ROUNDS = 31;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_BLOCKS = 210;

	// expected ciphertext and fault flag for every block in flight
	class cipher_board;
		typedef struct {
			logic [63:0] ct;
			logic        flt;
		} block_due_t;

		logic [79:0] key_a;
		logic [79:0] key_b;
		block_due_t  due[$];
		int          errors;

		function new();
			key_a = '0;
			key_b = '0;
			errors = 0;
		endfunction

		function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
			case (idx)
				REG_KEY_LOW: begin
					key_a[63:0] = d;
				end
				REG_KEY_HIGH: begin
					key_a[79:64] = d[15:0];
				end
				REG_KEY_DUP_LOW: begin
					key_b[63:0] = d;
				end
				REG_KEY_DUP_HIGH: begin
					key_b[79:64] = d[15:0];
				end
				default: begin
				end
			endcase
		endfunction

		function logic [3:0] sbox4(logic [3:0] n);
			case (n)
				4'h0: return 4'hc;
				4'h1: return 4'h5;
				4'h2: return 4'h6;
				4'h3: return 4'hb;
				4'h4: return 4'h9;
				4'h5: return 4'h0;
				4'h6: return 4'ha;
				4'h7: return 4'hd;
				4'h8: return 4'h3;
				4'h9: return 4'he;
				4'ha: return 4'hf;
				4'hb: return 4'h8;
				4'hc: return 4'h4;
				4'hd: return 4'h7;
				4'he: return 4'h1;
				default: return 4'h2;
			endcase
		endfunction

		function logic [63:0] nibble_sub(logic [63:0] s);
			logic [63:0] r;
			for (int n = 0; n < 16; n++) begin
				r[4*n +: 4] = sbox4(s[4*n +: 4]);
			end
			return r;
		endfunction

		// bit b goes to 16*b mod 63, the top bit stays put
		function logic [63:0] bit_perm(logic [63:0] s);
			logic [63:0] r;
			r[63] = s[63];
			for (int b = 0; b < 63; b++) begin
				r[(16 * b) % 63] = s[b];
			end
			return r;
		endfunction

		function logic [79:0] key_step(logic [79:0] k, int rc);
			logic [79:0] n;
			logic [4:0]  c;
			c = rc[4:0];
			n = {k[18:0], k[79:19]};
			n[79:76] = sbox4(n[79:76]);
			n[19:15] = n[19:15] ^ c;
			return n;
		endfunction

		function void block_taken(logic [63:0] p, logic [63:0] pd);
			logic [63:0] sa;
			logic [63:0] sb;
			logic [79:0] ka;
			logic [79:0] kb;
			block_due_t  e;
			sa = p;
			sb = pd;
			ka = key_a;
			kb = key_b;
			e.flt = (sa != sb) || (ka != kb);
			for (int r = 1; r <= ROUNDS; r++) begin
				sa = bit_perm(nibble_sub(sa ^ ka[79:16]));
				sb = bit_perm(nibble_sub(sb ^ kb[79:16]));
				ka = key_step(ka, r);
				kb = key_step(kb, r);
				if ((sa != sb) || (ka != kb))
					e.flt = 1'b1;
			end
			sa = sa ^ ka[79:16];
			sb = sb ^ kb[79:16];
			if (sa != sb)
				e.flt = 1'b1;
			e.ct = sa;
			due.push_back(e);
		endfunction

		function void block_out(logic [63:0] ct, logic flt);
			block_due_t e;
			if (due.size() == 0) begin
				$error("result with no block pending: ciphertext %h, fault %b", ct, flt);
				errors++;
			end else begin
				e = due.pop_front();
				if (ct !== e.ct) begin
					$error("ciphertext: expected %h, actual %h", e.ct, ct);
					errors++;
				end
				if (flt !== e.flt) begin
					$error("fault: expected %b, actual %b", e.flt, flt);
					errors++;
				end
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [BLK_W-1:0]     plaintext;
	logic [BLK_W-1:0]     plaintext_dup;
	logic                 done;
	logic [BLK_W-1:0]     ciphertext;
	logic                 fault;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BLK_W-1:0]     cfg_data;

	cipher_board board = new();
	int          cycles = 0;
	bit          idle_on = 1'b1;

	present80_block_encrypt_dual_check #(
		.ROUNDS(ROUNDS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.plaintext(plaintext),
		.plaintext_dup(plaintext_dup),
		.done(done),
		.ciphertext(ciphertext),
		.fault(fault),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.block_out(ciphertext, fault);
	end

	// start stays high from one block to the next unless an idle cycle falls between
	task automatic push_block(input logic [63:0] p, input logic [63:0] pd);
		if (idle_on) begin
			while ($urandom_range(99) < 12) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		plaintext <= p;
		plaintext_dup <= pd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.block_taken(p, pd);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
		if (idle_on) begin
			while ($urandom_range(99) < 12) begin
				cfg_valid <= 1'b0;
				@(posedge clk);
			end
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.load_reg(idx, d);
	endtask

	task automatic load_keys(input logic [63:0] lo, input logic [63:0] hi,
	                         input logic [63:0] dlo, input logic [63:0] dhi);
		write_reg(REG_KEY_LOW, lo);
		write_reg(REG_KEY_HIGH, hi);
		write_reg(REG_KEY_DUP_LOW, dlo);
		write_reg(REG_KEY_DUP_HIGH, dhi);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		logic [63:0] ones;
		logic [63:0] p;
		logic [63:0] pd;
		logic [79:0] k;
		logic [79:0] kd;
		logic [63:0] hi_data;
		logic [63:0] dhi_data;
		int          pick;

		ones = '1;
		arst_n <= 1'b0;
		start <= 1'b0;
		plaintext <= '0;
		plaintext_dup <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_KEY_LOW;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// keys still at their reset value
		push_block('0, '0);
		push_block(ones, ones);
		push_block(64'h1, 64'h1);
		push_block(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
		push_block('0, 64'h1);
		push_block(ones, ones ^ 64'h8000_0000_0000_0000);
		p = rand64();
		push_block(p, p);
		wait_idle();

		load_keys(ones, ones, ones, ones);
		push_block('0, '0);
		push_block(ones, ones);
		push_block(64'ha5a5_5a5a_0ff0_f00f, 64'ha5a5_5a5a_0ff0_f00f);
		push_block(rand64(), rand64());
		wait_idle();

		// lanes disagree only in the top key bit
		k = {16'($urandom), rand64()};
		load_keys(k[63:0], {48'd0, k[79:64]}, k[63:0], {48'd0, k[79:64] ^ 16'h8000});
		p = rand64();
		push_block(p, p);
		push_block('0, '0);
		push_block(ones, ones);
		wait_idle();

		// bits above the 16-bit high registers are dropped
		load_keys('0, 64'hffff_ffff_ffff_0000, '0, 64'h0000_0000_0000_0000);
		push_block('0, '0);
		p = rand64();
		push_block(p, p);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			idle_on = (ph != 4);
			k = {16'($urandom), rand64()};
			kd = k;
			hi_data = {48'd0, k[79:64]};
			dhi_data = hi_data;
			case (ph)
				0: begin
					hi_data = {48'(rand64()), k[79:64]};
					dhi_data = {48'(rand64()), k[79:64]};
				end
				1: begin
					k = '0;
					kd = '0;
					hi_data = '0;
					dhi_data = '0;
				end
				2: begin
					k = '1;
					kd = '1;
					hi_data = ones;
					dhi_data = ones;
				end
				3: begin
					kd = k ^ (80'd1 << $urandom_range(79));
					dhi_data = {48'd0, kd[79:64]};
				end
				6: begin
					kd[79:64] = 16'($urandom);
					dhi_data = {48'd0, kd[79:64]};
				end
				default: begin
				end
			endcase
			load_keys(k[63:0], hi_data, kd[63:0], dhi_data);
			for (int i = 0; i < PHASE_BLOCKS; i++) begin
				pick = $urandom_range(99);
				case ($urandom_range(15))
					0: p = '0;
					1: p = ones;
					default: p = rand64();
				endcase
				if (pick < 80)
					pd = p;
				else if (pick < 90)
					pd = p ^ (64'd1 << $urandom_range(63));
				else
					pd = rand64();
				push_block(p, pd);
			end
			// sender holds off until every pending result is out
			wait_idle();
		end

		wait_idle();
		repeat (ROUNDS + 8) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[present80_block_encrypt_dual_check.f]
rtl/core/p80dc_pkg.sv
rtl/core/p80dc_round.sv
rtl/core/present80_block_encrypt_dual_check.sv
bench/present80_block_encrypt_dual_check_tb.sv
